### sv/pidpr_pkg.sv
// Shared widths, register codes, state type and fixed-point helpers of the PID regulator.
`timescale 1ns / 1ps

package pidpr_pkg;

  localparam int TICK_W    = 32;
  localparam int GAIN_FRAC = 16;
  localparam int SHIFT     = GAIN_FRAC - 7;
  localparam int GAIN_W    = 24;
  localparam int Q15_W     = 16;
  localparam int ERR_W     = 17;
  localparam int DERR_W    = ERR_W + 1;
  localparam int MAG_W     = GAIN_W + DERR_W - 1;
  localparam int SV_W      = MAG_W + 1;
  localparam int CFG_AW    = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_MIN = 3'd3,
    REG_MAX = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PI,
    ST_DIV,
    ST_D,
    ST_OUT
  } state_t;

  // Sign-magnitude result of a serial multiplication.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } prod_t;

  function automatic logic signed [SV_W-1:0] to_signed(input logic neg,
                                                       input logic [MAG_W-1:0] mag);
    logic signed [SV_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Round half upwards, then arithmetic shift down to Q1.15.
  function automatic logic signed [SV_W-1:0] to_q15(input logic signed [SV_W-1:0] v);
    logic signed [SV_W-1:0] r;
    r = v + SV_W'(1 << (SHIFT - 1));
    return r >>> SHIFT;
  endfunction

  // The upper limit is tested first: with crossed limits a value above it gets it, any other the lower.
  function automatic logic signed [Q15_W-1:0] clamp(input logic signed [SV_W-1:0] v,
                                                    input logic signed [Q15_W-1:0] lo,
                                                    input logic signed [Q15_W-1:0] hi);
    logic signed [SV_W-1:0] lo_x;
    logic signed [SV_W-1:0] hi_x;
    lo_x = SV_W'(lo);
    hi_x = SV_W'(hi);
    if (v > hi_x) begin
      return hi;
    end else if (v < lo_x) begin
      return lo;
    end
    return v[Q15_W-1:0];
  endfunction

endpackage

### sv/pid_power_regulator_top.sv
// Top level of the PID power regulator: configuration, sequencing and result register.
`timescale 1ns / 1ps

// One sample is taken at a time. A sample is accepted while the block is idle, then three
// bit-serial multipliers form kp*err, ki*err and kd*(err - previous err), and a restoring
// divider divides the derivative product by the tick interval at one quotient bit a cycle
// over 41 bits, a step that is skipped when the tick interval is zero.
// The result register lets the next sample be accepted while a result still waits to be taken.
// Gains are signed Q8.16, temperatures signed Q8.8, and all outputs signed Q1.15, each clamped
// to the configured limits; if they cross, a value above the upper gets it, any other the lower.
module pid_power_regulator_top import pidpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // set_point[15:0], measured_temp[31:16], sample_tick[63:32]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // drive_power, prop_term, integ_term, deriv_term
  output logic              out_tuser,  // zero_interval
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [GAIN_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic signed [Q15_W-1:0]  min_r, max_r;
  logic signed [Q15_W-1:0]  integ_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic [TICK_W-1:0]        prev_tick_r;
  logic [TICK_W-1:0]        dt_r;
  logic                     zero_r;
  logic signed [SV_W-1:0]   pq_r, iq_r;
  logic signed [Q15_W-1:0]  p_r, i_r, d_r;
  logic                     out_valid_r;
  logic [63:0]              out_data_r;
  logic                     out_user_r;

  logic                     in_acc;
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic [TICK_W-1:0]        tick;
  logic signed [Q15_W-1:0]  i_new;
  logic signed [Q15_W-1:0]  d_new;
  logic signed [Q15_W-1:0]  sum_new;
  logic signed [SV_W-1:0]   d_raw;
  logic                     div_start;
  logic                     out_load;

  logic                     p_done, i_done, d_done, div_done;
  prod_t                    p_prod, i_prod, d_prod;
  logic [MAG_W-1:0]         quo;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign err  = $signed({in_tdata[15], in_tdata[15:0]}) - $signed({in_tdata[31], in_tdata[31:16]});
  assign derr = DERR_W'(err) - DERR_W'(prev_err_r);
  assign tick = TICK_W'(in_tdata[63:32]);

  pidpr_mul u_mul_p (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .gain(kp_r),
    .operand(DERR_W'(err)), .done(p_done), .prod(p_prod)
  );

  pidpr_mul u_mul_i (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .gain(ki_r),
    .operand(DERR_W'(err)), .done(i_done), .prod(i_prod)
  );

  pidpr_mul u_mul_d (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .gain(kd_r),
    .operand(derr), .done(d_done), .prod(d_prod)
  );

  pidpr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d_prod.mag),
    .divisor(dt_r), .done(div_done), .quotient(quo)
  );

  // All three multipliers run for the same number of cycles.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (p_done && i_done && d_done) begin
          state_nxt = ST_PI;
        end
      end
      ST_PI: begin
        div_start = !zero_r;
        state_nxt = zero_r ? ST_D : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_D;
        end
      end
      ST_D: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      min_r <= 16'sh8000;
      max_r <= 16'sh7fff;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_KP:  kp_r  <= cfg_data;
        REG_KI:  ki_r  <= cfg_data;
        REG_KD:  kd_r  <= cfg_data;
        REG_MIN: min_r <= cfg_data[Q15_W-1:0];
        REG_MAX: max_r <= cfg_data[Q15_W-1:0];
        default: ;
      endcase
    end
  end

  assign i_new   = clamp(SV_W'(integ_r) + iq_r, min_r, max_r);
  assign d_raw   = to_q15(to_signed(d_prod.neg, quo));
  assign d_new   = clamp(zero_r ? '0 : d_raw, min_r, max_r);
  assign sum_new = clamp(SV_W'(p_r) + SV_W'(i_r) + SV_W'(d_r), min_r, max_r);

  // The history is taken at acceptance, at the same edge at which the multipliers latch their operands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_tick_r <= '0;
    end else begin
      if (in_acc) begin
        prev_err_r  <= err;
        prev_tick_r <= tick;
      end
      if (state_r == ST_PI) begin
        integ_r <= i_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r   <= tick - prev_tick_r;
      zero_r <= (tick == prev_tick_r);
    end
    if (state_r == ST_MUL) begin
      pq_r <= to_q15(to_signed(p_prod.neg, p_prod.mag));
      iq_r <= to_q15(to_signed(i_prod.neg, i_prod.mag));
    end
    if (state_r == ST_PI) begin
      p_r <= clamp(pq_r, min_r, max_r);
      i_r <= i_new;
    end
    if (state_r == ST_D) begin
      d_r <= d_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {d_r, i_r, p_r, sum_new};
      out_user_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### sv/pidpr_mul.sv
// Bit-serial sign-magnitude multiplier of a gain by an error value.
`timescale 1ns / 1ps

module pidpr_mul import pidpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic signed [DERR_W-1:0] operand,
  output logic                     done,
  output prod_t                    prod
);

  localparam int CNT_W = $clog2(DERR_W);

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] mcand_r;
  logic [MAG_W-1:0] acc_r;
  logic [DERR_W-1:0] mplier_r;
  logic [GAIN_W-1:0] gain_abs;
  logic [DERR_W-1:0] op_abs;

  assign gain_abs = gain[GAIN_W-1] ? (~gain + 1'b1) : gain;
  assign op_abs   = operand[DERR_W-1] ? (~operand + 1'b1) : operand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DERR_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // One multiplier bit per cycle: add the shifted multiplicand when the bit is set.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= MAG_W'(gain_abs);
      mplier_r <= op_abs;
      acc_r    <= '0;
      cnt_r    <= '0;
      neg_r    <= gain[GAIN_W-1] ^ operand[DERR_W-1];
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[MAG_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[DERR_W-1:1]};
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign prod.neg = neg_r;
  assign prod.mag = acc_r;

endmodule

### sv/pidpr_div.sv
// Restoring divider that delivers one quotient bit per cycle.
`timescale 1ns / 1ps

module pidpr_div import pidpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [TICK_W-1:0] divisor,
  output logic              done,
  output logic [MAG_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(MAG_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  quo_r;
  logic [TICK_W-1:0] rem_r;
  logic [TICK_W-1:0] div_r;
  logic [TICK_W:0]   shifted;
  logic [TICK_W:0]   diff;

  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(MAG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The dividend shifts out of the top of the quotient register as quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (!diff[TICK_W]) begin
        rem_r <= diff[TICK_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[TICK_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
